// File: src/msbp_pkg.sv
`default_nettype none
package msbp_pkg;
  localparam int BLOCK_WORDS = 32;
  localparam int NUM_BLOCKS  = 4096;
  localparam int NUM_STACKS  = 1024;
  localparam int TW = $clog2(BLOCK_WORDS);
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int SW = $clog2(NUM_STACKS);
  localparam int AW = BW + TW;
  localparam int WORDS = NUM_BLOCKS * BLOCK_WORDS;
  localparam int GRP = 128;
  localparam int NGRP = NUM_BLOCKS / GRP;
  localparam int GW = $clog2(NGRP);
  localparam int LW = $clog2(GRP);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_LINK, S_EXEC, S_OUT
  } state_e;

  // head table entry: valid, block, top index
  typedef struct packed {
    logic          vld;
    logic [BW-1:0] blk;
    logic [TW-1:0] top;
  } head_t;

  // link table entry: valid previous, previous block
  typedef struct packed {
    logic          vld;
    logic [BW-1:0] blk;
  } link_t;

  // allocator request / answer
  typedef struct packed {
    logic          alloc;
    logic          free;
    logic [BW-1:0] free_blk;
  } alloc_req_t;

  typedef struct packed {
    logic          any;
    logic [BW-1:0] blk;
  } alloc_rsp_t;
endpackage
`default_nettype wire

// File: src/msbp_ram.sv
`default_nettype none
module msbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: src/msbp_alloc.sv
`default_nettype none
module msbp_alloc
  import msbp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire alloc_req_t req_i,
  output alloc_rsp_t      rsp_o
);
  // Two-level free map: one summary bit per group of GRP blocks, group
  // bitmaps in flip-flops (valid-bit style, cleared by reset).
  logic [GRP-1:0]  used_q [NGRP];
  logic [NGRP-1:0] full_q;
  logic [GW-1:0]   grp;
  logic [LW-1:0]   low;
  logic            gany, lany;

  always_comb begin
    gany = 1'b0;
    grp  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (!full_q[g]) begin
        gany = 1'b1;
        grp  = GW'(g);
      end
    end
    lany = 1'b0;
    low  = '0;
    for (int l = GRP - 1; l >= 0; l--) begin
      if (!used_q[grp][l]) begin
        lany = 1'b1;
        low  = LW'(l);
      end
    end
    rsp_o.any = gany && lany;
    rsp_o.blk = {grp, low};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NGRP; g++) used_q[g] <= '0;
      full_q <= '0;
    end else begin
      if (req_i.alloc) begin
        used_q[grp][low] <= 1'b1;
        full_q[grp] <= &(used_q[grp] | (GRP'(1) << low));
      end else if (req_i.free) begin
        used_q[req_i.free_blk[BW-1:LW]][req_i.free_blk[LW-1:0]] <= 1'b0;
        full_q[req_i.free_blk[BW-1:LW]] <= 1'b0;
      end
    end
  end

  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.alloc && req_i.free)) else $error("alloc and free together");
  a_alloc_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.alloc |-> rsp_o.any) else $error("alloc with no free block");
  a_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.alloc |=> used_q[$past(rsp_o.blk[BW-1:LW])][$past(rsp_o.blk[LW-1:0])])
    else $error("allocated block not marked");
endmodule
`default_nettype wire

// File: src/multi_stack_block_pool.sv
`default_nettype none
// Shared-pool stacks. Many LIFO stacks share one word memory cut into
// fixed-size blocks, with the lowest free block claimed on demand.
// Channels: s_axis (input item) tdata = {value, stack_id}, tuser = op
// (0 push, 1 pop). m_axis (result) tdata = {status, read_value}.
// Sequence: after the input transfer comes the head table read, then the
// link and word reads addressed by the head entry, then the
// read-modify-write, and then the result is presented on m_axis.
// Flow: items are handled one at a time, set by the chain of two registered
// reads and the one-deep result register; the next waits for the result.
// Reset: the head table has no per-entry valid flops, so after reset a
// clearing pass writes every head entry to empty, one per cycle, through all
// NUM_STACKS (1024) entries; no transfer is accepted meanwhile. The block
// free map lives in flip-flops and clears at once.
// Stall: a result holds on m_axis_tdata until taken; no new item is taken
// before that, so a stalled receiver stops the input side.
// Out-of-range stack ids cannot occur at the default size (10-bit id).
module multi_stack_block_pool
  import msbp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // stack_id[9:0], value[41:10], zero pad
  input  wire logic        s_axis_tuser,   // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // read_value[31:0], status[33:32], pad
);
  state_e state_q, state_d;

  logic [SW-1:0] clr_q;
  logic          op_q;
  logic [SW-1:0] sid_q;
  logic [31:0]   val_q;
  logic [31:0]   rv_q;
  logic [1:0]    st_q;

  // head table
  logic          h_we;
  logic [SW-1:0] h_waddr, h_raddr;
  head_t         h_wdata, h_rdata;
  // link table
  logic          l_we;
  logic [BW-1:0] l_waddr, l_raddr;
  link_t         l_wdata, l_rdata;
  // word memory
  logic          w_we;
  logic [AW-1:0] w_waddr, w_raddr;
  logic [31:0]   w_rdata;

  alloc_req_t areq;
  alloc_rsp_t arsp;

  logic acc_in, need_new;

  assign acc_in = s_axis_tvalid && s_axis_tready;

  msbp_ram #(.WIDTH($bits(head_t)), .DEPTH(NUM_STACKS)) u_head (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata));
  msbp_ram #(.WIDTH($bits(link_t)), .DEPTH(NUM_BLOCKS)) u_link (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(l_raddr), .rdata_o(l_rdata));
  msbp_ram #(.WIDTH(32), .DEPTH(WORDS)) u_word (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(val_q),
    .raddr_i(w_raddr), .rdata_o(w_rdata));
  msbp_alloc u_alloc (.clk_i, .rst_ni, .req_i(areq), .rsp_o(arsp));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == SW'(NUM_STACKS - 1)) state_d = S_IDLE;
      S_IDLE:  if (acc_in) state_d = S_READ;
      S_READ:  state_d = S_LINK;
      S_LINK:  state_d = S_EXEC;
      S_EXEC:  state_d = S_OUT;
      S_OUT:   if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  assign need_new = !h_rdata.vld || (h_rdata.top == TW'(BLOCK_WORDS - 1));

  // outputs and memory control
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    m_axis_tvalid = (state_q == S_OUT);
    h_raddr = sid_q;
    l_raddr = h_rdata.blk;
    w_raddr = {h_rdata.blk, h_rdata.top};
    h_we = 1'b0;
    h_waddr = sid_q;
    h_wdata = h_rdata;
    l_we = 1'b0;
    l_waddr = arsp.blk;
    l_wdata = '{vld: h_rdata.vld, blk: h_rdata.blk};
    w_we = 1'b0;
    w_waddr = {h_rdata.blk, h_rdata.top + TW'(1)};
    areq = '0;
    areq.free_blk = h_rdata.blk;
    case (state_q)
      S_CLEAR: begin
        h_we = 1'b1;
        h_waddr = clr_q;
        h_wdata = '0;
      end
      S_EXEC: begin
        if (op_q == OP_PUSH) begin
          if (need_new) begin
            if (arsp.any) begin
              areq.alloc = 1'b1;
              l_we = 1'b1;
              w_we = 1'b1;
              w_waddr = {arsp.blk, TW'(0)};
              h_we = 1'b1;
              h_wdata = '{vld: 1'b1, blk: arsp.blk, top: '0};
            end
          end else begin
            w_we = 1'b1;
            h_we = 1'b1;
            h_wdata.top = h_rdata.top + TW'(1);
          end
        end else if (h_rdata.vld) begin
          h_we = 1'b1;
          if (h_rdata.top == '0) begin
            areq.free = 1'b1;
            if (l_rdata.vld) h_wdata = '{vld: 1'b1, blk: l_rdata.blk, top: '1};
            else h_wdata = '0;
          end else begin
            h_wdata.top = h_rdata.top - TW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // The head entry lands in S_LINK and addresses the link and word reads,
  // whose data lands in S_EXEC; sid_q holds the head read address steady.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      sid_q <= s_axis_tdata[SW-1:0];
      val_q <= s_axis_tdata[41:10];
      op_q  <= s_axis_tuser;
    end
    if (state_q == S_EXEC) begin
      if (op_q == OP_PUSH) begin
        rv_q <= '0;
        st_q <= (need_new && !arsp.any) ? ST_NOFREE : ST_OK;
      end else begin
        rv_q <= h_rdata.vld ? w_rdata : 32'd0;
        st_q <= h_rdata.vld ? ST_OK : ST_EMPTY;
      end
    end
  end

  assign m_axis_tdata = {6'd0, st_q, rv_q};

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result held");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_acc_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in |=> state_q == S_READ) else $error("accept not followed by read");
endmodule
`default_nettype wire
